>>> rtl/core/multichannel_charge_and_current_stats_defines.svh
// Assertion macros shared by the checker of the charge and current stats block.
// Needs nothing else; included by the checker file.
`ifndef MULTICHANNEL_CHARGE_AND_CURRENT_STATS_DEFINES_SVH
`define MULTICHANNEL_CHARGE_AND_CURRENT_STATS_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define MCCS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MCCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mccs_pkg.sv
// Package of the charge and current stats block: widths, register indexes,
// controller states and the command/status bundles. No dependencies.
`default_nettype none

package mccs_pkg;

   localparam int MCCS_NUM_CHANNELS = 3;
   localparam int IN_CHANNELS       = 3;

   localparam int ELAPSED_W  = 16;
   localparam int CUR_W      = 19;
   localparam int CHAN_NUM_W = 2;
   localparam int CHARGE_W   = 64;
   localparam int SUM_W      = 64;
   localparam int PROD_W     = CUR_W + ELAPSED_W + 1;
   localparam int MASK_W     = 3;
   localparam int WLEN_W     = 8;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 128;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DISABLE_MASK  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = CSR_INDEX_W'(1);

   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(5);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_ROUND,
      ST_REP_CHECK,
      ST_REP_DIV,
      ST_REP_OUT
   } mccs_state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic acc;
      logic round_end;
      logic div_start;
      logic rsp_load;
   } mccs_cmd_type;

   typedef struct packed {
      logic window_end;
      logic chan_logging;
      logic more_logging;
      logic div_done;
      logic rsp_free;
   } mccs_status_type;

endpackage

`default_nettype wire

>>> rtl/core/mccs_div.sv
// Serial divider: signed 64-bit window sum by unsigned 8-bit round count,
// one quotient bit per cycle, result truncated toward zero and saturated to 19 bits.
// Depends on mccs_pkg.
`default_nettype none

module mccs_div
   import mccs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [SUM_W-1:0]  dividend,
   input  wire logic [WLEN_W-1:0]        divisor,
   output logic                          done,
   output logic signed [CUR_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] Q_POS_MAX = SUM_W'((64'd1 << (CUR_W - 1)) - 64'd1);
   localparam logic [SUM_W-1:0] Q_NEG_MAX = SUM_W'(64'd1 << (CUR_W - 1));
   localparam logic [CUR_W-1:0] SAT_POS = {1'b0, {(CUR_W-1){1'b1}}};
   localparam logic [CUR_W-1:0] SAT_NEG = {1'b1, {(CUR_W-1){1'b0}}};

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [WLEN_W-1:0] rem_ff, rem_in;
   logic [WLEN_W-1:0] dsr_ff, dsr_in;

   logic [WLEN_W:0]   trial;
   logic [WLEN_W:0]   diff;
   logic              ge;
   logic              last_step;

   assign trial     = {rem_ff, quo_ff[SUM_W-1]};
   assign diff      = trial - {1'b0, dsr_ff};
   assign ge        = trial >= {1'b0, dsr_ff};
   assign last_step = cnt_ff == CNT_W'(SUM_W - 1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[WLEN_W-1:0] : trial[WLEN_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > Q_NEG_MAX) ? SAT_NEG : -quo_ff[CUR_W-1:0];
      end else begin
         quotient = (quo_ff > Q_POS_MAX) ? SAT_POS : quo_ff[CUR_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

>>> rtl/core/mccs_dp.sv
// Datapath: configuration registers, per-channel window and charge state,
// charge multiplier, round counter, divider and the result register.
// Depends on mccs_pkg and mccs_div.
`default_nettype none

module mccs_dp
   import mccs_pkg::*;
#(
   parameter int NUM_CHANNELS = MCCS_NUM_CHANNELS,
   parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_data,
   input  wire logic [ELAPSED_W-1:0]       elapsed_ms,
   input  wire logic signed [CUR_W-1:0]    current_a,
   input  wire logic signed [CUR_W-1:0]    current_b,
   input  wire logic signed [CUR_W-1:0]    current_c,
   input  wire mccs_cmd_type               cmd,
   input  wire logic [CH_W-1:0]            chan,
   output mccs_status_type                 status,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [CHAN_NUM_W-1:0]           channel_number,
   output logic signed [CUR_W-1:0]         average_current,
   output logic signed [CUR_W-1:0]         minimum_current,
   output logic signed [CUR_W-1:0]         maximum_current,
   output logic signed [CHARGE_W-1:0]      charge_total,
   output logic                            last_report
);

   localparam logic signed [CHARGE_W-1:0] CHARGE_MAX = {1'b0, {(CHARGE_W-1){1'b1}}};
   localparam logic signed [CHARGE_W-1:0] CHARGE_MIN = {1'b1, {(CHARGE_W-1){1'b0}}};

   // configuration
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [WLEN_W-1:0] wlen_ff, wlen_in;

   // captured round
   logic [ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic signed [CUR_W-1:0] cap_ff [IN_CHANNELS];
   logic signed [CUR_W-1:0] cap_in [IN_CHANNELS];

   // per-channel state
   logic [NUM_CHANNELS-1:0]    logging_ff;
   logic signed [CUR_W-1:0]    min_ff    [NUM_CHANNELS];
   logic signed [CUR_W-1:0]    max_ff    [NUM_CHANNELS];
   logic signed [SUM_W-1:0]    sum_ff    [NUM_CHANNELS];
   logic signed [CHARGE_W-1:0] charge_ff [NUM_CHANNELS];

   logic signed [CUR_W-1:0]    min_in, max_in;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [CHARGE_W-1:0] charge_in;

   // multiplier stage
   logic signed [CUR_W-1:0]  cur_ff, cur_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic [WLEN_W-1:0] round_ff, round_in;
   logic [WLEN_W-1:0] divcnt_ff, divcnt_in;
   logic [WLEN_W-1:0] rc_next;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAN_NUM_W-1:0]      rsp_chan_ff;
   logic signed [CUR_W-1:0]    rsp_avg_ff, rsp_min_ff, rsp_max_ff;
   logic signed [CHARGE_W-1:0] rsp_charge_ff;
   logic                       rsp_last_ff;

   logic signed [CUR_W-1:0] cur_vec  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] mask_vec;
   logic                    active;
   logic                    more;
   logic signed [CHARGE_W:0] csum;
   logic                    div_done;
   logic signed [CUR_W-1:0] div_q;

   for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan_src
      if (i < IN_CHANNELS) begin : g_in
         assign cur_vec[i] = cap_ff[i];
      end else begin : g_zero
         assign cur_vec[i] = '0;
      end
      if (i < MASK_W) begin : g_mask
         assign mask_vec[i] = mask_ff[i];
      end else begin : g_nomask
         assign mask_vec[i] = 1'b0;
      end
   end

   // configuration writes
   always_comb begin
      mask_in = mask_ff;
      wlen_in = wlen_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DISABLE_MASK:  mask_in = csr_data[MASK_W-1:0];
            CSR_WINDOW_LENGTH: wlen_in = csr_data[WLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         wlen_ff <= WLEN_RESET;
      end else begin
         mask_ff <= mask_in;
         wlen_ff <= wlen_in;
      end
   end

   // capture of the round
   always_comb begin
      elapsed_in = elapsed_ff;
      cap_in     = cap_ff;
      if (cmd.capture) begin
         elapsed_in = elapsed_ms;
         cap_in[0]  = current_a;
         cap_in[1]  = current_b;
         cap_in[2]  = current_c;
      end
   end

   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      cap_ff     <= cap_in;
   end

   // charge product, registered before the accumulate
   assign cur_in  = cmd.mul ? cur_vec[chan] : cur_ff;
   assign prod_in = cmd.mul ? cur_vec[chan] * $signed({1'b0, elapsed_ff}) : prod_ff;

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
   end

   // channel update: silent until the first nonzero current
   assign active = !mask_vec[chan] && (logging_ff[chan] || (cur_ff != '0));
   assign csum   = $signed({charge_ff[chan][CHARGE_W-1], charge_ff[chan]})
                 + (CHARGE_W+1)'(prod_ff);

   always_comb begin
      if (round_ff != '0) begin
         max_in = max_ff[chan];
         min_in = min_ff[chan];
         if (cur_ff > max_ff[chan]) begin
            max_in = cur_ff;
         end else if (cur_ff < min_ff[chan]) begin
            min_in = cur_ff;
         end
         sum_in = sum_ff[chan] + SUM_W'(cur_ff);
      end else begin
         max_in = cur_ff;
         min_in = cur_ff;
         sum_in = SUM_W'(cur_ff);
      end
      if (csum[CHARGE_W] != csum[CHARGE_W-1]) begin
         charge_in = csum[CHARGE_W] ? CHARGE_MIN : CHARGE_MAX;
      end else begin
         charge_in = csum[CHARGE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         logging_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            min_ff[i]    <= '0;
            max_ff[i]    <= '0;
            sum_ff[i]    <= '0;
            charge_ff[i] <= '0;
         end
      end else if (cmd.acc && active) begin
         logging_ff[chan] <= 1'b1;
         min_ff[chan]     <= min_in;
         max_ff[chan]     <= max_in;
         sum_ff[chan]     <= sum_in;
         charge_ff[chan]  <= charge_in;
      end
   end

   // round counter and window close
   assign rc_next = round_ff + WLEN_W'(1);

   always_comb begin
      round_in  = round_ff;
      divcnt_in = divcnt_ff;
      if (cmd.round_end) begin
         if (rc_next >= wlen_ff) begin
            round_in  = '0;
            divcnt_in = (rc_next == '0) ? WLEN_W'(1) : rc_next;
         end else begin
            round_in = rc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
      end else begin
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      divcnt_ff <= divcnt_in;
   end

   mccs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff[chan]),
      .divisor  (divcnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // does a higher channel still report in this window
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if ((CH_W'(i) > chan) && logging_ff[i]) begin
            more = 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_chan_ff   <= CHAN_NUM_W'(chan);
         rsp_avg_ff    <= div_q;
         rsp_min_ff    <= min_ff[chan];
         rsp_max_ff    <= max_ff[chan];
         rsp_charge_ff <= charge_ff[chan];
         rsp_last_ff   <= !more;
      end
   end

   always_comb begin
      status.window_end   = rc_next >= wlen_ff;
      status.chan_logging = logging_ff[chan];
      status.more_logging = more;
      status.div_done     = div_done;
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign channel_number  = rsp_chan_ff;
   assign average_current = rsp_avg_ff;
   assign minimum_current = rsp_min_ff;
   assign maximum_current = rsp_max_ff;
   assign charge_total    = rsp_charge_ff;
   assign last_report     = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/mccs_ctrl.sv
// Controller: walks the channels for the update of one round, then through
// the reports when a window closes. Depends on mccs_pkg.
`default_nettype none

module mccs_ctrl
   import mccs_pkg::*;
#(
   parameter int NUM_CHANNELS = MCCS_NUM_CHANNELS,
   parameter int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mccs_status_type   status,
   output mccs_cmd_type           cmd,
   output logic [CH_W-1:0]        chan
);

   localparam logic [CH_W-1:0] LAST_CHAN = CH_W'(NUM_CHANNELS - 1);

   mccs_state_type  state_ff, state_in;
   logic [CH_W-1:0] chan_ff, chan_in;
   logic            last_chan;

   assign last_chan = chan_ff == LAST_CHAN;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
               chan_in  = '0;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_chan) begin
               state_in = ST_ROUND;
            end else begin
               state_in = ST_MUL;
               chan_in  = chan_ff + CH_W'(1);
            end
         end
         ST_ROUND: begin
            if (status.window_end) begin
               state_in = ST_REP_CHECK;
               chan_in  = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REP_CHECK: begin
            if (status.chan_logging) begin
               state_in = ST_REP_DIV;
            end else if (last_chan || !status.more_logging) begin
               state_in = ST_IDLE;
            end else begin
               chan_in = chan_ff + CH_W'(1);
            end
         end
         ST_REP_DIV: begin
            if (status.div_done) begin
               state_in = ST_REP_OUT;
            end
         end
         ST_REP_OUT: begin
            if (status.rsp_free) begin
               if (last_chan || !status.more_logging) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_REP_CHECK;
                  chan_in  = chan_ff + CH_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_MUL:       cmd.mul       = 1'b1;
         ST_ACC:       cmd.acc       = 1'b1;
         ST_ROUND:     cmd.round_end = 1'b1;
         ST_REP_CHECK: cmd.div_start = status.chan_logging;
         ST_REP_OUT:   cmd.rsp_load  = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

`default_nettype wire

>>> rtl/core/multichannel_charge_and_current_stats.sv
// Multichannel coulomb counter with windowed current statistics; top level.
// Depends on mccs_pkg, mccs_ctrl, mccs_dp (which holds mccs_div).
//
// req_ carries one measurement round per item: elapsed milliseconds and a
// signed current per input channel in 0.01 mA. req_tready is high only
// while the block is idle; one item is worked on at a time.
// A round runs one multiply and one accumulate step per channel, then a
// round-end step. When the round closes a window, each logging channel adds
// a division by the 64-step serial divider that forms the average.
// rsp_ delivers one item per logging channel, in channel order, rsp_tlast
// marking the last of the window. A quiet window yields no item.
// rsp_ has its own output register: a stalled receiver holds up only the
// next report; the block goes back to idle and takes a new round while the
// final report of a window still waits.
// csr_ writes a register by index (0: channel disable mask, 1: window
// length); csr_ready is always high. Write only while idle.
// reset (synchronous) clears the state, logging flags, round count and the
// valid flag of the result register; window length returns to 5 and the mask to zero.
`default_nettype none

module multichannel_charge_and_current_stats
   import mccs_pkg::*;
#(
   parameter int NUM_CHANNELS = MCCS_NUM_CHANNELS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // elapsed_ms[15:0], current_a[34:16], current_b[53:35], current_c[72:54]
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // channel_number[1:0], average_current[20:2], minimum_current[39:21],
   // maximum_current[58:40], charge_total[122:59]
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,
   output logic                          rsp_tlast,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   mccs_cmd_type               cmd;
   mccs_status_type            status;
   logic [CH_W-1:0]            chan;
   logic [CHAN_NUM_W-1:0]      channel_number;
   logic signed [CUR_W-1:0]    average_current;
   logic signed [CUR_W-1:0]    minimum_current;
   logic signed [CUR_W-1:0]    maximum_current;
   logic signed [CHARGE_W-1:0] charge_total;

   mccs_ctrl #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_W         (CH_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd),
      .chan      (chan)
   );

   mccs_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_W         (CH_W)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .elapsed_ms      (req_tdata[15:0]),
      .current_a       (req_tdata[34:16]),
      .current_b       (req_tdata[53:35]),
      .current_c       (req_tdata[72:54]),
      .cmd             (cmd),
      .chan            (chan),
      .status          (status),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .channel_number  (channel_number),
      .average_current (average_current),
      .minimum_current (minimum_current),
      .maximum_current (maximum_current),
      .charge_total    (charge_total),
      .last_report     (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, charge_total, maximum_current, minimum_current,
                       average_current, channel_number};
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

>>> rtl/core/mccs_checker.sv
// Port-level checker for the charge and current stats block, bound to the top.
// Depends on mccs_pkg and the assertion macro header.
`default_nettype none
`include "multichannel_charge_and_current_stats_defines.svh"

module mccs_checker
   import mccs_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tlast
);

   `MCCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp item dropped while stalled")
   `MCCS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")
   `MCCS_ASSERT_NEXT(a_one_round, clock, reset, req_tvalid && req_tready, !req_tready, "second round taken while busy")
   `MCCS_ASSERT_SAME(a_chan_range, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3, "report for a channel with no input")
   `MCCS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid, "rsp item present after reset")

endmodule

bind multichannel_charge_and_current_stats mccs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

>>> bench/multichannel_charge_and_current_stats_test.sv
// Self-checking bench for the multichannel charge and current stats block.
// Drives rounds and register writes with random gaps and checks every report.
// Depends on mccs_pkg and the top level multichannel_charge_and_current_stats.
`timescale 1ns / 1ps

module multichannel_charge_and_current_stats_test
   import mccs_pkg::*;
();

   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic [CHAN_NUM_W-1:0]    chan;
      logic signed [CUR_W-1:0]  avg;
      logic signed [CUR_W-1:0]  min;
      logic signed [CUR_W-1:0]  max;
      logic signed [63:0]       charge;
      logic                     last;
   } stats_report_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   multichannel_charge_and_current_stats i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predicted block state and registers
   logic [MASK_W-1:0]  disable_mask = '0;
   logic [WLEN_W-1:0]  window_len = WLEN_RESET;
   bit                 logging [MCCS_NUM_CHANNELS] = '{default: 0};
   int                 win_min [MCCS_NUM_CHANNELS] = '{default: 0};
   int                 win_max [MCCS_NUM_CHANNELS] = '{default: 0};
   longint             win_sum [MCCS_NUM_CHANNELS] = '{default: 0};
   longint             charge_acc [MCCS_NUM_CHANNELS] = '{default: 0};
   bit [WLEN_W-1:0]    rounds = '0;

   stats_report_type        pending_reports[$];
   logic [REQ_TDATA_W-1:0]  round_items[$];
   int                      rounds_queued = 0;
   int                      rounds_accepted = 0;
   int                      errors = 0;
   bit                      req_taken = 1'b0;
   bit                      no_idle = 1'b0;
   int                      send_gap = 0;
   int                      rsp_stall = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint sat_add(longint a, longint b);
      longint r;
      r = a + b;
      if (b > 0 && r < a)
         r = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (b < 0 && r > a)
         r = 64'sh8000_0000_0000_0000;
      return r;
   endfunction

   function automatic void predict_round(logic [REQ_TDATA_W-1:0] word);
      longint           ms;
      longint           divisor;
      longint           avg;
      int               cur;
      int               ch;
      int               n;
      stats_report_type rep;
      ms = longint'(word[ELAPSED_W-1:0]);
      n = 0;
      for (ch = 0; ch < MCCS_NUM_CHANNELS; ch++) begin
         if (disable_mask[ch])
            continue;
         cur = $signed(word[ELAPSED_W + CUR_W*ch +: CUR_W]);
         if (!logging[ch]) begin
            if (cur == 0)
               continue;
            logging[ch] = 1'b1;
         end
         if (rounds != 0) begin
            if (cur > win_max[ch])
               win_max[ch] = cur;
            else if (cur < win_min[ch])
               win_min[ch] = cur;
         end else begin
            win_min[ch] = cur;
            win_max[ch] = cur;
            win_sum[ch] = 0;
         end
         charge_acc[ch] = sat_add(charge_acc[ch], longint'(cur) * ms);
         win_sum[ch] += cur;
      end
      rounds = rounds + 1'b1;
      if (rounds >= window_len) begin
         divisor = (rounds != 0) ? longint'(rounds) : 1;
         for (ch = 0; ch < MCCS_NUM_CHANNELS; ch++) begin
            if (!logging[ch])
               continue;
            avg = win_sum[ch] / divisor;
            if (avg > 262143)
               avg = 262143;
            else if (avg < -262144)
               avg = -262144;
            rep.chan   = ch[CHAN_NUM_W-1:0];
            rep.avg    = avg[CUR_W-1:0];
            rep.min    = win_min[ch][CUR_W-1:0];
            rep.max    = win_max[ch][CUR_W-1:0];
            rep.charge = charge_acc[ch];
            rep.last   = 1'b0;
            pending_reports.push_back(rep);
            n++;
         end
         if (n > 0)
            pending_reports[$].last = 1'b1;
         rounds = '0;
      end
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int rand_current();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 262143;
         1: return -262144;
         2: return 0;
         3, 4: return int'($urandom_range(0, 200)) - 100;
         default: return int'($urandom_range(0, 524287)) - 262144;
      endcase
   endfunction

   function automatic int rand_elapsed();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 0;
         1: return 65535;
         2, 3, 4: return 200;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // monitor: reports are checked before a newly accepted round is predicted
   always @(posedge clock) begin
      stats_report_type rep;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               $error("report item with none expected: channel %0d", rsp_tdata[1:0]);
               errors++;
            end else begin
               rep = pending_reports.pop_front();
               check_field("channel_number", rep.chan, rsp_tdata[1:0]);
               check_field("average_current", rep.avg, $signed(rsp_tdata[20:2]));
               check_field("minimum_current", rep.min, $signed(rsp_tdata[39:21]));
               check_field("maximum_current", rep.max, $signed(rsp_tdata[58:40]));
               check_field("charge_total", rep.charge, $signed(rsp_tdata[122:59]));
               check_field("last_report", rep.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_round(req_tdata);
            rounds_accepted++;
         end
      end
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // round driver
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            next_valid = 1'b0;
         end else if (round_items.size() > 0) begin
            req_tdata <= round_items.pop_front();
            next_valid = 1'b1;
            if (!no_idle && $urandom_range(0, 2) == 0)
               send_gap <= gap_len();
         end else begin
            next_valid = 1'b0;
         end
      end
      req_tvalid <= next_valid;
   end

   // report receiver stalls
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 2) == 0)
            rsp_stall <= gap_len();
      end
   end

   task automatic send_round(int ms, int a, int b, int c);
      round_items.push_back({{(REQ_TDATA_W-73){1'b0}}, c[18:0], b[18:0], a[18:0], ms[15:0]});
      rounds_queued++;
   endtask

   // wait until every round is taken and every report is in, then let the
   // block finish a round that causes no report
   task automatic wait_idle();
      do @(negedge clock);
      while (rounds_accepted != rounds_queued || pending_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_DISABLE_MASK)
         disable_mask = value[MASK_W-1:0];
      else if (idx == CSR_WINDOW_LENGTH)
         window_len = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase;
      int count;
      int i;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // quiet window: nothing logging yet
      write_reg(CSR_WINDOW_LENGTH, 8'd1);
      send_round(100, 0, 0, 0);

      // late start of channels a and b, extremes of every field
      write_reg(CSR_WINDOW_LENGTH, 8'd3);
      send_round(200, 0, 0, 0);
      send_round(65535, 262143, 0, 0);
      send_round(0, -262144, -1, 0);
      send_round(200, 1, 1, 5);

      // zero window length ends every round
      write_reg(CSR_WINDOW_LENGTH, 8'd0);
      send_round(1000, -5, 7, 262143);
      send_round(65535, 100, -100, -262144);

      // disabled while logging: still reported with held values
      write_reg(CSR_DISABLE_MASK, 8'd1);
      send_round(200, 999, 2, 3);
      write_reg(CSR_DISABLE_MASK, 8'd6);
      send_round(200, -7, 8, 9);

      // stale sum across a window start drives the average past the top
      write_reg(CSR_DISABLE_MASK, 8'd0);
      write_reg(CSR_WINDOW_LENGTH, 8'd2);
      send_round(10, 0, 262143, 0);
      send_round(10, 0, 262143, 0);
      write_reg(CSR_DISABLE_MASK, 8'd2);
      send_round(10, 1, 1, 1);
      write_reg(CSR_DISABLE_MASK, 8'd0);
      send_round(10, 2, 262143, 2);

      // same toward the bottom
      send_round(10, 0, 0, -262144);
      send_round(10, 0, 0, -262144);
      write_reg(CSR_DISABLE_MASK, 8'd4);
      send_round(10, 1, 1, 1);
      write_reg(CSR_DISABLE_MASK, 8'd0);
      send_round(10, 3, 3, -262144);

      // random phases; each boundary holds the sender until all reports are in
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_DISABLE_MASK, 8'd0);
               write_reg(CSR_WINDOW_LENGTH, 8'd1);
               count = 25;
            end
            1: begin
               write_reg(CSR_DISABLE_MASK, 8'd7);
               write_reg(CSR_WINDOW_LENGTH, 8'd2);
               count = 10;
            end
            5: begin
               write_reg(CSR_DISABLE_MASK, 8'd0);
               write_reg(CSR_WINDOW_LENGTH, 8'd0);
               count = 15;
            end
            6: begin
               write_reg(CSR_DISABLE_MASK, CSR_DATA_W'($urandom_range(0, 7)));
               write_reg(CSR_WINDOW_LENGTH, 8'd255);
               count = 256;
            end
            7: begin
               write_reg(CSR_DISABLE_MASK, 8'd5);
               write_reg(CSR_WINDOW_LENGTH, 8'd4);
               count = 10;
            end
            default: begin
               write_reg(CSR_DISABLE_MASK, CSR_DATA_W'($urandom_range(0, 7)));
               write_reg(CSR_WINDOW_LENGTH, CSR_DATA_W'($urandom_range(1, 8)));
               count = 20;
            end
         endcase
         no_idle = (phase == 2) || ($urandom_range(0, 3) == 0);
         for (i = 0; i < count; i++)
            send_round(rand_elapsed(), rand_current(), rand_current(), rand_current());
      end

      wait_idle();
      if (errors == 0 && pending_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
